/* sv/bcss_pkg.sv */
package bcss_pkg;

	localparam int COORD_BITS = 32;
	localparam int CNT_W      = 17;
	localparam int TOL_W      = 16;
	localparam int AXIS_W     = 2;

	// count saturation: smaller of the particle limit and the field maximum
	localparam int MAX_PARTICLES = 65536;
	localparam int CNT_FIELD_MAX = (1 << CNT_W) - 1;
	localparam int CNT_CAP_INT   = (MAX_PARTICLES < CNT_FIELD_MAX) ? MAX_PARTICLES
		: CNT_FIELD_MAX;
	localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_INT);

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 136;

	localparam int PADDR_W = 4;

	// register indexes, taken from paddr[3:2]
	localparam logic [1:0] REG_CUT_POSITION  = 2'd0;
	localparam logic [1:0] REG_CUT_AXIS      = 2'd1;
	localparam logic [1:0] REG_TIE_TOLERANCE = 2'd2;

	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;

	typedef struct packed {
		logic [COORD_BITS-1:0] cut_position;
		logic [AXIS_W-1:0]     cut_axis;
		logic [TOL_W-1:0]      tie_tolerance;
	} cfg_t;

	// classified particle, as queued between front and back
	typedef struct packed {
		logic                  side;
		logic                  last;
		logic [COORD_BITS-1:0] coord;
	} entry_t;

	typedef struct packed {
		logic                  side;
		logic                  summary_valid;
		logic [CNT_W-1:0]      total_lower;
		logic [CNT_W-1:0]      total_upper;
		logic [COORD_BITS-1:0] max_lower;
		logic [CNT_W-1:0]      count_lower;
		logic                  lower_found;
		logic [COORD_BITS-1:0] min_upper;
		logic [CNT_W-1:0]      count_upper;
		logic                  upper_found;
	} res_t;

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return (c < CNT_CAP) ? c + CNT_W'(1) : c;
	endfunction

	function automatic logic ties(input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b, input logic [TOL_W-1:0] tol);
		logic [COORD_BITS-1:0] d;
		d = (a > b) ? a - b : b - a;
		return d <= COORD_BITS'(tol);
	endfunction

endpackage

/* sv/bcss_regs.sv */
module bcss_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bcss_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output bcss_pkg::cfg_t               cfg
);
	import bcss_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_CUT_POSITION:  cfg_q.cut_position  <= pwdata;
				REG_CUT_AXIS:      cfg_q.cut_axis      <= pwdata[AXIS_W-1:0];
				REG_TIE_TOLERANCE: cfg_q.tie_tolerance <= pwdata[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_CUT_POSITION:  prdata = cfg_q.cut_position;
			REG_CUT_AXIS:      prdata = {{(32-AXIS_W){1'b0}}, cfg_q.cut_axis};
			REG_TIE_TOLERANCE: prdata = {{(32-TOL_W){1'b0}}, cfg_q.tie_tolerance};
			default:           prdata = '0;
		endcase
	end

endmodule

/* sv/bcss_front.sv */
module bcss_front (
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bcss_pkg::IN_TDATA_W-1:0] s_tdata,
	input  logic                            s_tlast,
	input  bcss_pkg::cfg_t                  cfg,
	output logic                            push_valid,
	input  logic                            push_ready,
	output bcss_pkg::entry_t                push_entry
);
	import bcss_pkg::*;

	logic [COORD_BITS-1:0] coord;

	// axis code three falls through to z
	always_comb begin
		case (cfg.cut_axis)
			AXIS_X:  coord = s_tdata[31:0];
			AXIS_Y:  coord = s_tdata[63:32];
			default: coord = s_tdata[95:64];
		endcase
	end

	assign s_tready         = push_ready;
	assign push_valid       = s_tvalid;
	assign push_entry.coord = coord;
	assign push_entry.last  = s_tlast;
	assign push_entry.side  = ~(coord < cfg.cut_position);

endmodule

/* sv/bcss_queue.sv */
module bcss_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  bcss_pkg::entry_t wr_entry,
	output logic             rd_valid,
	input  logic             rd_ready,
	output bcss_pkg::entry_t rd_entry
);
	import bcss_pkg::*;

	entry_t                slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     fill_q;
	logic                  push;
	logic                  pop;

	assign wr_ready = (fill_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign rd_valid = (fill_q != '0);
	assign push     = wr_valid & wr_ready;
	assign pop      = rd_valid & rd_ready;
	assign rd_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + (QUEUE_AW+1)'(1);
				2'b01:   fill_q <= fill_q - (QUEUE_AW+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* sv/bcss_back.sv */
module bcss_back (
	input  logic             clk,
	input  logic             arst_n,
	input  bcss_pkg::cfg_t   cfg,
	input  logic             rd_valid,
	output logic             rd_ready,
	input  bcss_pkg::entry_t rd_entry,
	output logic             res_valid,
	input  logic             res_ready,
	output bcss_pkg::res_t   res
);
	import bcss_pkg::*;

	logic [CNT_W-1:0]      lo_total_q, up_total_q, lo_cnt_q, up_cnt_q;
	logic [COORD_BITS-1:0] lo_ext_q, up_ext_q;
	logic                  lo_seen_q, up_seen_q;

	logic [CNT_W-1:0]      lo_total_n, up_total_n, lo_cnt_n, up_cnt_n;
	logic [COORD_BITS-1:0] lo_ext_n, up_ext_n;
	logic                  lo_seen_n, up_seen_n;

	logic                  res_valid_q;
	res_t                  res_q;
	res_t                  res_n;
	logic                  take;

	// output register frees up in the same cycle it is drained
	assign rd_ready  = ~res_valid_q | res_ready;
	assign take      = rd_valid & rd_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		lo_total_n = lo_total_q;
		up_total_n = up_total_q;
		lo_cnt_n   = lo_cnt_q;
		up_cnt_n   = up_cnt_q;
		lo_ext_n   = lo_ext_q;
		up_ext_n   = up_ext_q;
		lo_seen_n  = lo_seen_q;
		up_seen_n  = up_seen_q;
		if (!rd_entry.side) begin
			lo_total_n = bump(lo_total_q);
			if (!lo_seen_q) begin
				lo_seen_n = 1'b1;
				lo_ext_n  = rd_entry.coord;
				lo_cnt_n  = CNT_W'(1);
			end else if (ties(rd_entry.coord, lo_ext_q, cfg.tie_tolerance)) begin
				lo_cnt_n = bump(lo_cnt_q);
			end else if (rd_entry.coord > lo_ext_q) begin
				lo_ext_n = rd_entry.coord;
				lo_cnt_n = CNT_W'(1);
			end
		end else begin
			up_total_n = bump(up_total_q);
			if (!up_seen_q) begin
				up_seen_n = 1'b1;
				up_ext_n  = rd_entry.coord;
				up_cnt_n  = CNT_W'(1);
			end else if (ties(rd_entry.coord, up_ext_q, cfg.tie_tolerance)) begin
				up_cnt_n = bump(up_cnt_q);
			end else if (rd_entry.coord < up_ext_q) begin
				up_ext_n = rd_entry.coord;
				up_cnt_n = CNT_W'(1);
			end
		end
	end

	// summary fields stay zero except on the last word of a pass
	always_comb begin
		res_n      = '0;
		res_n.side = rd_entry.side;
		if (rd_entry.last) begin
			res_n.summary_valid = 1'b1;
			res_n.total_lower   = lo_total_n;
			res_n.total_upper   = up_total_n;
			res_n.max_lower     = lo_ext_n;
			res_n.count_lower   = lo_cnt_n;
			res_n.lower_found   = lo_seen_n;
			res_n.min_upper     = up_ext_n;
			res_n.count_upper   = up_cnt_n;
			res_n.upper_found   = up_seen_n;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			lo_total_q  <= '0;
			up_total_q  <= '0;
			lo_cnt_q    <= '0;
			up_cnt_q    <= '0;
			lo_ext_q    <= '0;
			up_ext_q    <= '0;
			lo_seen_q   <= 1'b0;
			up_seen_q   <= 1'b0;
		end else begin
			if (take) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (take && rd_entry.last) begin
				lo_total_q <= '0;
				up_total_q <= '0;
				lo_cnt_q   <= '0;
				up_cnt_q   <= '0;
				lo_ext_q   <= '0;
				up_ext_q   <= '0;
				lo_seen_q  <= 1'b0;
				up_seen_q  <= 1'b0;
			end else if (take) begin
				lo_total_q <= lo_total_n;
				up_total_q <= up_total_n;
				lo_cnt_q   <= lo_cnt_n;
				up_cnt_q   <= up_cnt_n;
				lo_ext_q   <= lo_ext_n;
				up_ext_q   <= up_ext_n;
				lo_seen_q  <= lo_seen_n;
				up_seen_q  <= up_seen_n;
			end
		end
	end

endmodule

/* sv/bisection_cut_slab_scan.sv */
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   s_tdata pos_x,pos_y,pos_z; s_tlast last
// m_*       out  m_tvalid/m_tready   m_tdata side..upper_found; m_tlast summary_valid
// apb       in   psel/penable        paddr 0 cut_position, 4 cut_axis, 8 tie_tolerance
//
// one word per cycle unless m_tready stalls; back end updates all pass state per word
// a word is registered in the queue, then in the output register, before its result appears
// a four-entry queue between classify and accumulate absorbs output stalls
// reset clears the queue, pass state and registers at once, no clearing pass
module bisection_cut_slab_scan (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// pos_x [31:0], pos_y [63:32], pos_z [95:64]
	input  logic [bcss_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// side [0], total_lower [17:1], total_upper [34:18], max_lower [66:35],
	// count_lower [83:67], lower_found [84], min_upper [116:85],
	// count_upper [133:117], upper_found [134], zero [135]
	output logic [bcss_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                             m_tlast,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bcss_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import bcss_pkg::*;

	cfg_t   cfg;
	entry_t push_entry, pop_entry;
	logic   push_valid, push_ready, pop_valid, pop_ready;
	res_t   res;

	bcss_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bcss_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	bcss_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_entry (push_entry),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_entry (pop_entry)
	);

	bcss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.rd_valid  (pop_valid),
		.rd_ready  (pop_ready),
		.rd_entry  (pop_entry),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tlast = res.summary_valid;
	assign m_tdata = {1'b0, res.upper_found, res.count_upper, res.min_upper,
		res.lower_found, res.count_lower, res.max_lower, res.total_upper,
		res.total_lower, res.side};

endmodule

/* sv/bcss_chk.sv */
module bcss_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [135:0] m_tdata,
	input logic         m_tlast
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result word changed");

	// words inside a pass carry no summary
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[135:1] == '0)
		else $error("summary fields set on a non-last word");

	// the last word counts itself on its own side
	a_own_side: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[0] ? m_tdata[134] : m_tdata[84])
			&& (m_tdata[0] ? m_tdata[34:18] != '0 : m_tdata[17:1] != '0))
		else $error("last word missing from its side");

	// an empty side reports zero extreme and zero ties
	a_empty_side: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[84] || m_tdata[83:1] == '0 ||
			m_tdata[83:35] == '0 && m_tdata[17:1] == '0)
			&& (m_tdata[134] || m_tdata[133:85] == '0 && m_tdata[34:18] == '0))
		else $error("empty side reports data");

endmodule

bind bisection_cut_slab_scan bcss_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
